FILE: design/tama_pkg.sv
// ----------------------------------------------------------------------------
// tama_pkg
// Shared widths, constants and types of the three-axis accelerometer
// moving-average filter.
// ----------------------------------------------------------------------------
`default_nettype none

package tama_pkg;

   localparam int DATA_W         = 16;
   localparam int BYTE_W         = 8;
   localparam int AXES           = 3;
   localparam int WINDOW_DEFAULT = 10;
   localparam int MEAN_SHIFT     = 32;

   // one g = 417.95 counts; Q8.8 scale 256 -> 2 * 25600 / 41795 with rounding
   localparam longint unsigned GRAV_NUM2 = 64'd51200;
   localparam longint unsigned GRAV_DEN  = 64'd41795;

   localparam logic signed [DATA_W-1:0] ZERO_FILL   = '0;
   localparam logic signed [DATA_W-1:0] Z_FILL_INIT = 16'sd418;

   typedef struct packed {
      logic shift_en;
      logic load_en;
      logic prod_en;
   } ctl_type;

endpackage

`default_nettype wire

FILE: design/tama_axis_filter.sv
// ----------------------------------------------------------------------------
// tama_axis_filter
// One axis: sample shift line, running window sum and scaled mean product.
// ----------------------------------------------------------------------------
`default_nettype none

module tama_axis_filter #(
   parameter int                                   WINDOW      = tama_pkg::WINDOW_DEFAULT,
   parameter logic signed [tama_pkg::DATA_W-1:0]   RESET_VALUE = tama_pkg::ZERO_FILL
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire tama_pkg::ctl_type                     ctl,
   input  wire logic signed [tama_pkg::DATA_W-1:0]    sample,
   input  wire logic signed [tama_pkg::DATA_W-1:0]    fill,
   output logic signed [tama_pkg::DATA_W-1:0]         mean
);

   localparam int DATA_W = tama_pkg::DATA_W;
   localparam int SUM_W  = DATA_W + $clog2(WINDOW);
   localparam longint unsigned MEAN_RECIP =
      (((64'd1 << tama_pkg::MEAN_SHIFT) * tama_pkg::GRAV_NUM2)
       / (tama_pkg::GRAV_DEN * WINDOW) + 64'd1) / 64'd2;
   localparam int RECIP_W = $clog2(MEAN_RECIP + 64'd1);
   localparam int PROD_W  = SUM_W + RECIP_W + 1;

   localparam logic signed [RECIP_W:0]  RECIP_S   = (RECIP_W+1)'(MEAN_RECIP);
   localparam logic signed [SUM_W-1:0]  WINDOW_S  = SUM_W'(WINDOW);
   localparam logic signed [SUM_W-1:0]  RESET_SUM = SUM_W'(RESET_VALUE * WINDOW_S);

   logic signed [DATA_W-1:0] line_ff [WINDOW];
   logic signed [DATA_W-1:0] line_in [WINDOW];
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [SUM_W-1:0]  fill_sum;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign fill_sum = SUM_W'(fill * WINDOW_S);
   assign prod_in  = PROD_W'(sum_ff) * PROD_W'(RECIP_S);

   always_comb begin
      line_in = line_ff;
      sum_in  = sum_ff;
      if (ctl.load_en) begin
         for (int i = 0; i < WINDOW; i++) begin
            line_in[i] = fill;
         end
         sum_in = fill_sum;
      end else if (ctl.shift_en) begin
         line_in[0] = sample;
         for (int i = 1; i < WINDOW; i++) begin
            line_in[i] = line_ff[i-1];
         end
         sum_in = sum_ff - SUM_W'(line_ff[WINDOW-1]) + SUM_W'(sample);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            line_ff[i] <= RESET_VALUE;
         end
         sum_ff <= RESET_SUM;
      end else begin
         line_ff <= line_in;
         sum_ff  <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.prod_en) begin
         prod_ff <= prod_in;
      end
   end

   assign mean = prod_ff[tama_pkg::MEAN_SHIFT +: DATA_W];

endmodule

`default_nettype wire

FILE: design/three_axis_accel_moving_average_unit.sv
// An accepted req beat is registered in the sum stage and then the result stage before rsp_tvalid.
// Throughput: one beat per cycle unless a result is held; the running-sum and
// mean product registers set it and advance with a one-deep result stage.
// Reset: x and y windows clear to zero, z window fills with 418 counts (one g),
// pipeline empties. A csr write refills the whole z window at once.
// ----------------------------------------------------------------------------
// three_axis_accel_moving_average_unit
// Boxcar mean of three accelerometer axes over WINDOW samples, in Q8.8 g.
// ----------------------------------------------------------------------------
`default_nettype none

module three_axis_accel_moving_average_unit #(
   parameter int WINDOW = tama_pkg::WINDOW_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // x_low_byte, x_high_byte, y_low_byte, y_high_byte, z_low_byte, z_high_byte
   input  wire logic [6*tama_pkg::BYTE_W-1:0]      req_tdata,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // x_mean_g, y_mean_g, z_mean_g
   output logic [3*tama_pkg::DATA_W-1:0]           rsp_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic                               csr_we,
   input  wire logic [tama_pkg::DATA_W-1:0]        csr_wdata
);

   localparam int DATA_W = tama_pkg::DATA_W;

   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              pipe_en;
   logic              req_fire;
   tama_pkg::ctl_type ctl_xy;
   tama_pkg::ctl_type ctl_z;

   logic signed [DATA_W-1:0] sample [tama_pkg::AXES];
   logic signed [DATA_W-1:0] mean   [tama_pkg::AXES];

   assign pipe_en    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || pipe_en;
   assign req_fire   = req_tvalid && req_tready;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !pipe_en);
   assign rsp_valid_in = pipe_en ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      ctl_xy.shift_en = req_fire;
      ctl_xy.load_en  = 1'b0;
      ctl_xy.prod_en  = s1_valid_ff && pipe_en;
      ctl_z           = ctl_xy;
      ctl_z.load_en   = csr_we;
   end

   always_comb begin
      for (int a = 0; a < tama_pkg::AXES; a++) begin
         sample[a] = req_tdata[a*DATA_W +: DATA_W];
      end
   end

   tama_axis_filter #(
      .WINDOW      (WINDOW),
      .RESET_VALUE (tama_pkg::ZERO_FILL)
   ) u_axis_x (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl_xy),
      .sample (sample[0]),
      .fill   (tama_pkg::ZERO_FILL),
      .mean   (mean[0])
   );

   tama_axis_filter #(
      .WINDOW      (WINDOW),
      .RESET_VALUE (tama_pkg::ZERO_FILL)
   ) u_axis_y (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl_xy),
      .sample (sample[1]),
      .fill   (tama_pkg::ZERO_FILL),
      .mean   (mean[1])
   );

   tama_axis_filter #(
      .WINDOW      (WINDOW),
      .RESET_VALUE (tama_pkg::Z_FILL_INIT)
   ) u_axis_z (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl_z),
      .sample (sample[2]),
      .fill   (csr_wdata),
      .mean   (mean[2])
   );

   assign rsp_tdata  = {mean[2], mean[1], mean[0]};
   assign rsp_tvalid = rsp_valid_ff;

   a_accept_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted beat did not enter the sum stage");

   a_advance_shows_result: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && pipe_en) |=> rsp_tvalid)
      else $error("advanced beat did not reach the result stage");

   a_full_pipe_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("new beat accepted while both stages are held");

endmodule

`default_nettype wire
